// File: hdl/teup_pkg.sv
// teup_pkg: shared types and constants for the terminal escape / utf-8 parser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package teup_pkg;

    typedef enum logic [3:0] {
        M_NORMAL, M_ESC, M_TITLE, M_G0, M_G1, M_CSI, M_CSI_PREFIX, M_CSI_NUM, M_CSI_SUFFIX
    } mode_t;

    typedef enum logic [2:0] {
        EV_ASCII   = 3'd0,
        EV_UNICODE = 3'd1,
        EV_ESC     = 3'd2,
        EV_CHARSET = 3'd3,
        EV_PARAM   = 3'd4,
        EV_DONE    = 3'd5
    } event_t;

    typedef enum logic [1:0] {
        S_RUN, S_DUMP_RD, S_DUMP
    } seq_t;

    localparam logic [7:0] CH_ESC = 8'h1b;
    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [15:0] PARAM_SAT = 16'hffff;

    typedef struct packed {
        logic [7:0] data_byte;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [20:0] char_code;
        logic [6:0]  csi_prefix;
        logic [6:0]  csi_second_suffix;
        logic [15:0] param_value;
        logic [3:0]  param_index;
        logic [4:0]  param_total;
        logic        last_of_run;
    } out_beat_t;

endpackage
`default_nettype wire

// File: hdl/teup_if.sv
// teup_if: valid/ready channel carrying one beat of a given payload type
// no dependencies; the payload type comes from parameter T
`timescale 1ns / 1ps
`default_nettype none
interface teup_if #(parameter type T = logic) (input wire logic clk);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: hdl/terminal_escape_utf8_parser.sv
// terminal_escape_utf8_parser: one byte a cycle while output is free and no dump runs;
// csi parameters in a registered-read memory; a result appears the cycle after its byte.
// a csi final holds off input while its parameters dump: a read then send per beat,
// done included, the send waiting while the output stalls.
// digits update the open parameter from a register copy of its last written value.
// reset: asynchronous, active low; control returns to normal mode, memory is not cleared.
// depends on teup_pkg and teup_if
`timescale 1ns / 1ps
`default_nettype none
module terminal_escape_utf8_parser #(
    parameter int MAX_PARAMS = 16
) (
    input wire logic clk,
    input wire logic rst_n,
    teup_if.sink     in_ch,
    teup_if.source   out_ch
);
    import teup_pkg::*;

    localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int CW = $clog2(MAX_PARAMS + 1);

    // parameter memory
    logic [15:0] mem [MAX_PARAMS];
    logic [15:0] rd_data_reg;
    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [15:0] wdata;

    mode_t mode_reg, mode_next;
    seq_t  seq_reg, seq_next;
    logic [6:0] prefix_reg, prefix_next, suf_reg, suf_next, suf2_reg, suf2_next;
    logic first_reg, first_next, ovf_reg, ovf_next;
    logic [CW-1:0] cnt_reg, cnt_next, idx_reg, idx_next;
    logic [1:0] need_reg, need_next, pos_reg, pos_next;
    logic [20:0] acc_reg, acc_next;
    logic bad_reg, bad_next;
    // last written value, forwarded for back-to-back digits
    logic [15:0] last_reg, last_next;
    logic        ov_reg, ov_next;
    out_beat_t   ob_reg, ob_next;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    logic accept, out_free;
    assign out_free = !ov_reg || out_ch.ready;
    assign in_ch.ready = (seq_reg == S_RUN) && out_free;
    assign accept = in_ch.valid && in_ch.ready;
    assign out_ch.valid = ov_reg;
    assign out_ch.payload = ob_reg;

    logic [7:0] b;
    logic cont, dig;
    logic [20:0] cp;
    logic [19:0] mul;
    logic cpbad;
    logic [3:0] dval;

    always_comb
    begin
        b = in_ch.payload.data_byte;
        mode_next = mode_reg; seq_next = seq_reg;
        prefix_next = prefix_reg; suf_next = suf_reg; suf2_next = suf2_reg;
        first_next = first_reg; ovf_next = ovf_reg; cnt_next = cnt_reg;
        idx_next = idx_reg; need_next = need_reg; pos_next = pos_reg;
        acc_next = acc_reg; bad_next = bad_reg; last_next = last_reg;
        ov_next = ov_reg && !out_ch.ready; ob_next = ob_reg;
        we = 1'b0; waddr = '0; wdata = last_reg; raddr = idx_reg[AW-1:0];
        cont = (b[7:6] == 2'b10);
        dig = (b >= 8'h30) && (b <= 8'h39);
        dval = b[3:0];
        mul = {1'b0, last_reg, 3'b0} + {3'b0, last_reg, 1'b0} + {16'b0, dval};
        cp = '0; cpbad = 1'b0;
        unique case (seq_reg)
            S_RUN:
            begin
                if (accept)
                begin
                    logic fresh;
                    fresh = 1'b0;
                    ob_next = '0;
                    ob_next.last_of_run = 1'b1;
                    if (need_reg != 2'd0)
                    begin
                        if ({1'b0, pos_reg} + 3'd1 < {1'b0, need_reg})
                        begin
                            pos_next = pos_reg + 2'd1;
                            if (!cont) bad_next = 1'b1;
                            acc_next = {acc_reg[14:0], b[5:0]};
                        end
                        else if (bad_reg || !cont)
                        begin
                            fresh = 1'b1;
                            acc_next = '0;
                        end
                        else
                        begin
                            cp = {acc_reg[14:0], b[5:0]};
                            if (need_reg == 2'd1) cpbad = cp < 21'h80;
                            else if (need_reg == 2'd2)
                                cpbad = cp < 21'h800 || cp[20:11] == 10'h1b;
                            else cpbad = cp < 21'h10000 || cp > 21'h10ffff;
                            need_next = '0; pos_next = '0; bad_next = 1'b0; acc_next = '0;
                            if (mode_reg == M_NORMAL)
                            begin
                                ov_next = 1'b1;
                                ob_next.event_kind = EV_UNICODE;
                                ob_next.char_code = cpbad ? 21'h3f : cp;
                            end
                        end
                    end
                    else
                    begin
                        fresh = 1'b1;
                    end
                    if (fresh)
                    begin
                        pos_next = '0; bad_next = 1'b0; need_next = '0;
                        if (!b[7])
                        begin
                            // escape state machine
                            unique case (mode_reg)
                                M_CSI_SUFFIX:
                                begin
                                    suf2_next = b[6:0];
                                    mode_next = M_NORMAL;
                                    idx_next = '0; seq_next = S_DUMP_RD;
                                end
                                M_CSI, M_CSI_NUM, M_CSI_PREFIX:
                                begin
                                    if (mode_reg == M_CSI &&
                                        (b == 8'h21 || b == 8'h3f || b == 8'h3e))
                                    begin
                                        mode_next = M_CSI_PREFIX;
                                        prefix_next = b[6:0];
                                    end
                                    else if (dig)
                                    begin
                                        if (mode_reg == M_CSI) mode_next = M_CSI_NUM;
                                        if (first_reg)
                                        begin
                                            first_next = 1'b0; ovf_next = 1'b0;
                                            if (cnt_reg < CW'(MAX_PARAMS))
                                            begin
                                                we = 1'b1; waddr = cnt_reg[AW-1:0];
                                                wdata = {12'b0, dval};
                                                last_next = wdata;
                                                cnt_next = cnt_reg + 1'b1;
                                            end
                                            else ovf_next = 1'b1;
                                        end
                                        else if (!ovf_reg && cnt_reg != '0)
                                        begin
                                            we = 1'b1;
                                            waddr = AW'(cnt_reg - 1'b1);
                                            wdata = (mul > 20'hffff) ? PARAM_SAT : mul[15:0];
                                            last_next = wdata;
                                        end
                                    end
                                    else if (b == 8'h3b)
                                    begin
                                        if (mode_reg == M_CSI) mode_next = M_CSI_NUM;
                                        if (first_reg)
                                        begin
                                            if (cnt_reg < CW'(MAX_PARAMS))
                                            begin
                                                we = 1'b1; waddr = cnt_reg[AW-1:0];
                                                wdata = '0; last_next = '0;
                                                cnt_next = cnt_reg + 1'b1;
                                            end
                                            else ovf_next = 1'b1;
                                        end
                                        else first_next = 1'b1;
                                    end
                                    else
                                    begin
                                        suf_next = b[6:0];
                                        if (b == 8'h22 || b == 8'h27) mode_next = M_CSI_SUFFIX;
                                        else
                                        begin
                                            mode_next = M_NORMAL;
                                            idx_next = '0; seq_next = S_DUMP_RD;
                                        end
                                    end
                                end
                                M_G0, M_G1:
                                begin
                                    mode_next = M_NORMAL; ov_next = 1'b1;
                                    ob_next.event_kind = EV_CHARSET;
                                    ob_next.char_code = {13'b0, b};
                                end
                                M_TITLE:
                                begin
                                    if (b == CH_BEL) mode_next = M_NORMAL;
                                end
                                M_ESC:
                                begin
                                    if (b > 8'd15)
                                    begin
                                        mode_next = M_NORMAL;
                                        if (b == 8'h5d) mode_next = M_TITLE;
                                        else if (b == 8'h5b)
                                        begin
                                            mode_next = M_CSI;
                                            prefix_next = '0; suf_next = '0; suf2_next = '0;
                                            first_next = 1'b1; cnt_next = '0; ovf_next = 1'b0;
                                        end
                                        else if (b == 8'h28) mode_next = M_G0;
                                        else if (b == 8'h29) mode_next = M_G1;
                                        else if (b == 8'h44 || b == 8'h4d || b == 8'h45 ||
                                                 b == 8'h37 || b == 8'h38 || b == 8'h3d ||
                                                 b == 8'h3e || b == 8'h4e || b == 8'h4f ||
                                                 b == 8'h63 || b == 8'h48)
                                        begin
                                            ov_next = 1'b1;
                                            ob_next.event_kind = EV_ESC;
                                            ob_next.char_code = {13'b0, b};
                                        end
                                    end
                                end
                                default:
                                begin
                                    if (b == CH_ESC) mode_next = M_ESC;
                                    else
                                    begin
                                        ov_next = 1'b1;
                                        ob_next.event_kind = EV_ASCII;
                                        ob_next.char_code = {13'b0, b};
                                    end
                                end
                            endcase
                        end
                        else if (b[7:5] == 3'b110)
                        begin
                            need_next = 2'd1; acc_next = {16'b0, b[4:0]};
                        end
                        else if (b[7:4] == 4'b1110)
                        begin
                            need_next = 2'd2; acc_next = {17'b0, b[3:0]};
                        end
                        else if (b[7:3] == 5'b11110)
                        begin
                            need_next = 2'd3; acc_next = {18'b0, b[2:0]};
                        end
                    end
                end
            end
            S_DUMP_RD:
            begin
                // read of entry idx issued this cycle
                raddr = idx_reg[AW-1:0];
                seq_next = S_DUMP;
            end
            S_DUMP:
            begin
                // keep the read address so the data stays put while the output stalls
                raddr = idx_reg[AW-1:0];
                if (out_free)
                begin
                    ov_next = 1'b1;
                    ob_next = '0;
                    ob_next.char_code = {14'b0, suf_reg};
                    ob_next.csi_prefix = prefix_reg;
                    ob_next.csi_second_suffix = suf2_reg;
                    ob_next.param_total = 5'(cnt_reg);
                    if (idx_reg < cnt_reg)
                    begin
                        ob_next.event_kind = EV_PARAM;
                        ob_next.param_value = rd_data_reg;
                        ob_next.param_index = 4'(idx_reg);
                        idx_next = idx_reg + 1'b1;
                        seq_next = S_DUMP_RD;
                    end
                    else
                    begin
                        ob_next.event_kind = EV_DONE;
                        ob_next.last_of_run = 1'b1;
                        seq_next = S_RUN;
                        prefix_next = '0; suf_next = '0; suf2_next = '0;
                        first_next = 1'b1; cnt_next = '0; ovf_next = 1'b0;
                    end
                end
            end
            default: seq_next = S_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_NORMAL; seq_reg <= S_RUN;
            prefix_reg <= '0; suf_reg <= '0; suf2_reg <= '0;
            first_reg <= 1'b1; ovf_reg <= 1'b0; cnt_reg <= '0; idx_reg <= '0;
            need_reg <= '0; pos_reg <= '0; acc_reg <= '0; bad_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next; seq_reg <= seq_next;
            prefix_reg <= prefix_next; suf_reg <= suf_next; suf2_reg <= suf2_next;
            first_reg <= first_next; ovf_reg <= ovf_next; cnt_reg <= cnt_next;
            idx_reg <= idx_next; need_reg <= need_next; pos_reg <= pos_next;
            acc_reg <= acc_next; bad_reg <= bad_next; ov_reg <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        ob_reg <= ob_next;
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_PARAMS)) else $error("param count overflow");
    a_no_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg != S_RUN |-> !in_ch.ready) else $error("input taken during dump");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !out_ch.ready |=> ov_reg && $stable(ob_reg)) else $error("result lost");
`endif

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// tb_top: self-checking bench for terminal_escape_utf8_parser, byte stream in, events out
// depends on teup_pkg, teup_if and the parser rtl
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import teup_pkg::*;

    localparam int NPARAM = 16;
    localparam int WATCHDOG = 20000;

    logic clk;
    logic rst_n;

    teup_if #(.T(in_beat_t))  in_ch (.clk(clk));
    teup_if #(.T(out_beat_t)) out_ch (.clk(clk));

    terminal_escape_utf8_parser #(.MAX_PARAMS(NPARAM)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    // predictor state
    mode_t       pm_mode;
    logic [6:0]  pm_prefix;
    logic        pm_first_digit;
    logic [15:0] pm_params [NPARAM];
    int          pm_count;
    logic [6:0]  pm_suffix1;
    logic [6:0]  pm_suffix2;
    logic        pm_overflow;
    int          pm_utf_need;
    int          pm_utf_pos;
    logic [20:0] pm_utf_acc;
    logic        pm_utf_bad;

    out_beat_t   expected_events [$];
    logic [7:0]  pending_bytes [$];
    int          hold_marks [$];
    int          errors;
    bit          stim_done;
    bit          calm;
    int          sent_count;
    int          watchdog;

    task automatic push_event(input event_t k, input logic [20:0] code,
                              input logic [6:0] pre, input logic [6:0] s2,
                              input logic [15:0] val, input int idx, input int tot);
        out_beat_t e;
        e.event_kind = k;
        e.char_code = code;
        e.csi_prefix = pre;
        e.csi_second_suffix = s2;
        e.param_value = val;
        e.param_index = idx[3:0];
        e.param_total = tot[4:0];
        e.last_of_run = 1'b0;
        expected_events.push_back(e);
    endtask

    task automatic csi_reset_state();
        pm_prefix = '0;
        pm_suffix1 = '0;
        pm_suffix2 = '0;
        pm_first_digit = 1'b1;
        pm_count = 0;
        pm_overflow = 1'b0;
    endtask

    task automatic csi_flush();
        for (int i = 0; i < pm_count; i++)
            push_event(EV_PARAM, {14'd0, pm_suffix1}, pm_prefix, pm_suffix2,
                       pm_params[i], i, pm_count);
        push_event(EV_DONE, {14'd0, pm_suffix1}, pm_prefix, pm_suffix2, 16'd0, 0, pm_count);
    endtask

    task automatic csi_add(input logic [15:0] v);
        if (pm_count < NPARAM)
        begin
            pm_params[pm_count] = v;
            pm_count++;
        end
        else
            pm_overflow = 1'b1;
    endtask

    task automatic csi_digit(input logic [7:0] c);
        int v;
        if (pm_first_digit)
        begin
            pm_first_digit = 1'b0;
            pm_overflow = 1'b0;
            csi_add(16'(c - 8'd48));
        end
        else if (!pm_overflow && pm_count > 0)
        begin
            v = int'(pm_params[pm_count-1]) * 10 + int'(c - 8'd48);
            pm_params[pm_count-1] = (v > 65535) ? PARAM_SAT : 16'(v);
        end
    endtask

    task automatic csi_semi();
        if (pm_first_digit)
            csi_add(16'd0);
        else
            pm_first_digit = 1'b1;
    endtask

    task automatic csi_final(input logic [7:0] c);
        pm_suffix1 = c[6:0];
        if (c == "\"" || c == "'")
            pm_mode = M_CSI_SUFFIX;
        else
        begin
            pm_mode = M_NORMAL;
            csi_flush();
        end
    endtask

    // escape state machine for 7-bit bytes
    task automatic ascii_step(input logic [7:0] c);
        logic digit;
        digit = (c >= "0" && c <= "9");
        case (pm_mode)
            M_CSI_SUFFIX:
            begin
                pm_suffix2 = c[6:0];
                pm_mode = M_NORMAL;
                csi_flush();
            end
            M_CSI_NUM, M_CSI_PREFIX:
            begin
                if (digit) csi_digit(c);
                else if (c == ";") csi_semi();
                else csi_final(c);
            end
            M_G0, M_G1:
            begin
                pm_mode = M_NORMAL;
                push_event(EV_CHARSET, {13'd0, c}, '0, '0, '0, 0, 0);
            end
            M_CSI:
            begin
                if (c == "!" || c == "?" || c == ">")
                begin
                    pm_mode = M_CSI_PREFIX;
                    pm_prefix = c[6:0];
                end
                else if (digit)
                begin
                    pm_mode = M_CSI_NUM;
                    csi_digit(c);
                end
                else if (c == ";")
                begin
                    pm_mode = M_CSI_NUM;
                    csi_semi();
                end
                else
                    csi_final(c);
            end
            M_TITLE:
            begin
                if (c == CH_BEL) pm_mode = M_NORMAL;
            end
            M_ESC:
            begin
                if (c > 8'd15)
                begin
                    case (c)
                        "]": pm_mode = M_TITLE;
                        "[":
                        begin
                            pm_mode = M_CSI;
                            csi_reset_state();
                        end
                        "(": pm_mode = M_G0;
                        ")": pm_mode = M_G1;
                        "D", "M", "E", "7", "8", "=", ">", "N", "O", "c", "H":
                        begin
                            pm_mode = M_NORMAL;
                            push_event(EV_ESC, {13'd0, c}, '0, '0, '0, 0, 0);
                        end
                        default: pm_mode = M_NORMAL;
                    endcase
                end
            end
            default:
            begin
                if (c == CH_ESC) pm_mode = M_ESC;
                else push_event(EV_ASCII, {13'd0, c}, '0, '0, '0, 0, 0);
            end
        endcase
    endtask

    task automatic fresh_step(input logic [7:0] b);
        pm_utf_pos = 0;
        pm_utf_bad = 1'b0;
        if (b < 8'h80)
        begin
            pm_utf_need = 0;
            ascii_step(b);
        end
        else if ((b & 8'hE0) == 8'hC0)
        begin
            pm_utf_need = 1;
            pm_utf_acc = {16'd0, b[4:0]};
        end
        else if ((b & 8'hF0) == 8'hE0)
        begin
            pm_utf_need = 2;
            pm_utf_acc = {17'd0, b[3:0]};
        end
        else if ((b & 8'hF8) == 8'hF0)
        begin
            pm_utf_need = 3;
            pm_utf_acc = {18'd0, b[2:0]};
        end
        else
            pm_utf_need = 0;
    endtask

    // one input byte: utf-8 collection, then escape handling
    task automatic predict_byte(input logic [7:0] b);
        int first;
        logic cont;
        logic bad;
        logic [20:0] cp;
        first = expected_events.size();
        cont = (b[7:6] == 2'b10);
        if (pm_utf_need != 0)
        begin
            if (pm_utf_pos + 1 < pm_utf_need)
            begin
                pm_utf_pos++;
                if (!cont) pm_utf_bad = 1'b1;
                pm_utf_acc = {pm_utf_acc[14:0], b[5:0]};
            end
            else if (pm_utf_bad || !cont)
            begin
                pm_utf_need = 0;
                pm_utf_acc = '0;
                fresh_step(b);
            end
            else
            begin
                cp = {pm_utf_acc[14:0], b[5:0]};
                if (pm_utf_need == 1) bad = cp < 21'h80;
                else if (pm_utf_need == 2) bad = cp < 21'h800 || cp[20:11] == 10'h1B;
                else bad = cp < 21'h10000 || cp > 21'h10FFFF;
                pm_utf_need = 0;
                pm_utf_pos = 0;
                pm_utf_bad = 1'b0;
                pm_utf_acc = '0;
                if (pm_mode == M_NORMAL)
                    push_event(EV_UNICODE, bad ? 21'h3F : cp, '0, '0, '0, 0, 0);
            end
        end
        else
            fresh_step(b);
        if (expected_events.size() > first)
            expected_events[expected_events.size()-1].last_of_run = 1'b1;
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // driver: idles in bursts, holds for marked pauses
    int send_gap;
    int hold_mark;
    bit holding;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.payload <= '0;
            send_gap <= 0;
            holding <= 1'b0;
        end
        else
        begin : drv
            bit fire;
            bit busy;
            fire = in_ch.valid && in_ch.ready;
            if (fire)
            begin
                predict_byte(in_ch.payload.data_byte);
                sent_count = sent_count + 1;
            end
            busy = in_ch.valid && !fire;
            if (!busy)
            begin
                if (hold_marks.size() > 0 && hold_marks[0] == sent_count
                    && expected_events.size() != 0)
                    in_ch.valid <= 1'b0;
                else if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_bytes.size() > 0)
                begin
                    if (hold_marks.size() > 0 && hold_marks[0] == sent_count)
                        void'(hold_marks.pop_front());
                    in_ch.valid <= 1'b1;
                    in_ch.payload.data_byte <= pending_bytes.pop_front();
                    if (!calm && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 5);
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                    stim_done <= 1'b1;
                end
            end
        end
    end

    // monitor: stalls in bursts, checks each beat against the oldest expectation
    int sink_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            sink_gap <= 0;
            watchdog <= 0;
        end
        else
        begin : mon
            out_beat_t got;
            out_beat_t want;
            got = out_ch.payload;
            if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
                watchdog <= 0;
            else
                watchdog <= watchdog + 1;
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("unexpected event beat kind=%0d code=%0h", got.event_kind,
                           got.char_code);
                    errors++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (got.event_kind !== want.event_kind)
                    begin
                        $error("event_kind exp %0d got %0d", want.event_kind, got.event_kind);
                        errors++;
                    end
                    if (got.char_code !== want.char_code)
                    begin
                        $error("char_code exp %0h got %0h", want.char_code, got.char_code);
                        errors++;
                    end
                    if (got.csi_prefix !== want.csi_prefix)
                    begin
                        $error("csi_prefix exp %0h got %0h", want.csi_prefix, got.csi_prefix);
                        errors++;
                    end
                    if (got.csi_second_suffix !== want.csi_second_suffix)
                    begin
                        $error("csi_second_suffix exp %0h got %0h", want.csi_second_suffix,
                               got.csi_second_suffix);
                        errors++;
                    end
                    if (got.param_value !== want.param_value)
                    begin
                        $error("param_value exp %0d got %0d", want.param_value, got.param_value);
                        errors++;
                    end
                    if (got.param_index !== want.param_index)
                    begin
                        $error("param_index exp %0d got %0d", want.param_index, got.param_index);
                        errors++;
                    end
                    if (got.param_total !== want.param_total)
                    begin
                        $error("param_total exp %0d got %0d", want.param_total, got.param_total);
                        errors++;
                    end
                    if (got.last_of_run !== want.last_of_run)
                    begin
                        $error("last_of_run exp %0d got %0d", want.last_of_run, got.last_of_run);
                        errors++;
                    end
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap <= sink_gap - 1;
                out_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 6) == 0)
            begin
                sink_gap <= $urandom_range(0, 4);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            pending_bytes.push_back(s[i]);
    endtask

    task automatic add_utf(input int cp, input int nbytes);
        if (nbytes == 1)
        begin
            pending_bytes.push_back(8'hC0 | 8'((cp >> 6) & 8'h1F));
        end
        else if (nbytes == 2)
        begin
            pending_bytes.push_back(8'hE0 | 8'((cp >> 12) & 8'h0F));
            pending_bytes.push_back(8'h80 | 8'((cp >> 6) & 8'h3F));
        end
        else
        begin
            pending_bytes.push_back(8'hF0 | 8'((cp >> 18) & 8'h07));
            pending_bytes.push_back(8'h80 | 8'((cp >> 12) & 8'h3F));
            pending_bytes.push_back(8'h80 | 8'((cp >> 6) & 8'h3F));
        end
        pending_bytes.push_back(8'h80 | 8'(cp & 8'h3F));
    endtask

    // random well-formed csi with zero to four random parameters
    task automatic add_csi();
        int np;
        pending_bytes.push_back(CH_ESC);
        pending_bytes.push_back("[");
        case ($urandom_range(0, 3))
            0: pending_bytes.push_back("?");
            1: pending_bytes.push_back(">");
            2: pending_bytes.push_back("!");
            default: ;
        endcase
        np = $urandom_range(0, 4);
        for (int i = 0; i < np; i++)
        begin
            if ($urandom_range(0, 4) != 0)
                add_str($sformatf("%0d", ($urandom_range(0, 9) == 0) ?
                        $urandom_range(60000, 999999) : $urandom_range(0, 300)));
            if (i != np - 1) pending_bytes.push_back(";");
        end
        if ($urandom_range(0, 4) == 0)
        begin
            pending_bytes.push_back($urandom_range(0, 1) ? "\"" : "'");
            pending_bytes.push_back(8'($urandom_range(0, 127)));
        end
        else
            pending_bytes.push_back(8'($urandom_range(64, 126)));
    endtask

    // test sequence
    initial
    begin
        errors = 0;
        stim_done = 0;
        calm = 0;
        sent_count = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        pm_mode = M_NORMAL;
        csi_reset_state();
        pm_utf_need = 0;
        pm_utf_pos = 0;
        pm_utf_acc = '0;
        pm_utf_bad = 1'b0;

        // directed: ascii extremes, escapes, charsets, title, csi corner cases, utf-8
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'h7F);
        add_str("A");
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'h80);
        add_utf(16'h00E9, 1);
        add_utf(16'h20AC, 2);
        add_utf(21'h10FFFF, 3);
        add_utf(16'h0041, 1);
        add_utf(16'hD800, 2);
        add_utf(21'h110000, 3);
        pending_bytes.push_back(8'hE2);
        pending_bytes.push_back(8'h41);
        add_str("BC");
        pending_bytes.push_back(CH_ESC);
        pending_bytes.push_back(8'h05);
        add_str("D");
        pending_bytes.push_back(CH_ESC);
        add_str("Z");
        pending_bytes.push_back(CH_ESC);
        add_str("]title");
        pending_bytes.push_back(CH_BEL);
        pending_bytes.push_back(CH_ESC);
        add_str("(B");
        pending_bytes.push_back(CH_ESC);
        add_str(")0");
        pending_bytes.push_back(CH_ESC);
        add_str("[?99999;;7h");
        pending_bytes.push_back(CH_ESC);
        add_str("[1;2;3;4;5;6;7;8;9;10;11;12;13;14;15;16;17;18p");
        pending_bytes.push_back(CH_ESC);
        add_str("[4\"q");
        pending_bytes.push_back(CH_ESC);
        add_str("[");
        add_utf(16'h00E9, 1);
        add_str("m");
        hold_marks.push_back(pending_bytes.size());

        // random: mostly well-formed sequences, some noise
        for (int n = 0; n < 4; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: add_csi();
                3: pending_bytes.push_back(8'($urandom_range(0, 255)));
                4:
                begin
                    pending_bytes.push_back(CH_ESC);
                    pending_bytes.push_back(8'($urandom_range(0, 127)));
                    pending_bytes.push_back(8'($urandom_range(32, 126)));
                end
                5: add_utf($urandom_range(0, 21'h1FFFFF) >> $urandom_range(0, 12),
                           $urandom_range(1, 3));
                6:
                begin
                    pending_bytes.push_back(8'($urandom_range(8'hC0, 8'hF7)));
                    pending_bytes.push_back(8'($urandom_range(0, 255)));
                    pending_bytes.push_back(8'($urandom_range(0, 255)));
                end
                default: pending_bytes.push_back(8'($urandom_range(32, 126)));
            endcase
            if (n == 2) hold_marks.push_back(pending_bytes.size());
        end
        pending_bytes.push_back(8'h20);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // last stretch runs with no idling
        wait (pending_bytes.size() < 40);
        calm = 1;
        wait (stim_done && expected_events.size() == 0);
        repeat (40) @(posedge clk);
        $display("covered %0d bytes: ascii, utf-8 good and bad, escapes, charsets, title,",
                 sent_count);
        $display("csi with prefixes, saturation, parameter overflow and second suffix");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog on stalled traffic
    initial
    begin
        wait (rst_n);
        wait (watchdog >= WATCHDOG);
        $display("timeout after %0d idle cycles", watchdog);
        $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
hdl/teup_pkg.sv
hdl/teup_if.sv
hdl/terminal_escape_utf8_parser.sv
bench/tb_top.sv
